// ----- rtl/mep_pkg.sv -----
// shared types, constants and palette for the mandelbrot escape pixel core
package mep_pkg;

   localparam int FRAC_BITS = 28;

   // configuration register indexes
   localparam logic [2:0] CSR_MIN_X     = 3'd0;
   localparam logic [2:0] CSR_INC_X     = 3'd1;
   localparam logic [2:0] CSR_MIN_Y     = 3'd2;
   localparam logic [2:0] CSR_INC_Y     = 3'd3;
   localparam logic [2:0] CSR_MAX_ITER  = 3'd4;
   localparam logic [2:0] CSR_FILL      = 3'd5;

   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] inc_x;
      logic signed [31:0] min_y;
      logic signed [31:0] inc_y;
      logic [15:0]        max_iterations;
      logic [23:0]        fill_color;
   } mep_cfg_type;

   // result handed from the sequencer to the output stage
   typedef struct packed {
      logic        valid;
      logic [15:0] count;
   } mep_done_type;

   function automatic logic [23:0] mep_palette(input logic [2:0] idx);
      logic [23:0] c;
      case (idx)
         3'd0:    c = 24'h04182B;
         3'd1:    c = 24'h5A8C8C;
         3'd2:    c = 24'hF2D99D;
         3'd3:    c = 24'h738585;
         3'd4:    c = 24'hAB1111;
         3'd5:    c = 24'h04182B;
         3'd6:    c = 24'h5A8C8C;
         default: c = 24'hF2D99D;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/mep_csr.sv -----
// configuration register file
module mep_csr import mep_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output mep_cfg_type       cfg
);

   mep_cfg_type cfg_ff;
   mep_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_X:    cfg_in.min_x          = csr_data;
            CSR_INC_X:    cfg_in.inc_x          = csr_data;
            CSR_MIN_Y:    cfg_in.min_y          = csr_data;
            CSR_INC_Y:    cfg_in.inc_y          = csr_data;
            CSR_MAX_ITER: cfg_in.max_iterations = csr_data[15:0];
            CSR_FILL:     cfg_in.fill_color     = csr_data[23:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_x          <= 32'shE000_0000;
         cfg_ff.inc_x          <= 32'sd786432;
         cfg_ff.min_y          <= 32'shE800_0000;
         cfg_ff.inc_y          <= 32'sd786432;
         cfg_ff.max_iterations <= 16'd256;
         cfg_ff.fill_color     <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/mep_mul.sv -----
// shared signed 32x32 multiplier with registered product
module mep_mul import mep_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [31:0] mul_b,
   output logic signed [63:0] prod
);

   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/mep_seq.sv -----
// iteration sequencer and point datapath around the shared multiplier
module mep_seq import mep_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mep_cfg_type   cfg,
   input  logic          start,
   input  logic [9:0]    row,
   input  logic [9:0]    col,
   output logic          idle,
   input  logic          take,
   output mep_done_type  done
);

   typedef enum logic [3:0] {
      S_IDLE, S_SETX, S_SETY, S_LOAD, S_CHECK, S_XX, S_YY, S_XY, S_DONE
   } state_type;

   localparam logic signed [45:0] LIM     = 46'sh0000_4000_0000;
   localparam logic [34:0]        ESC_LIM = 35'h1_0000_0000;

   state_type          state_ff, state_in;
   logic [9:0]         row_ff, row_in, col_ff, col_in;
   logic signed [43:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] zx_ff, zx_in, zy_ff, zy_in;
   logic [33:0]        xx_ff, xx_in, yy_ff, yy_in;
   logic [15:0]        k_ff, k_in;
   logic [15:0]        count_ff, count_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;
   logic signed [33:0] prod_sh;
   logic signed [45:0] nx, ny;
   logic [34:0]        mag_sum;
   logic               out_of_box;

   mep_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // floor shift of the product back to the fixed point grid
   assign prod_sh = prod[FRAC_BITS+33:FRAC_BITS];

   assign nx = $signed({12'd0, xx_ff}) - $signed({12'd0, yy_ff})
             + $signed({{2{cx_ff[43]}}, cx_ff});
   assign ny = $signed({{11{prod_sh[33]}}, prod_sh, 1'b0})
             + $signed({{2{cy_ff[43]}}, cy_ff});
   assign out_of_box = (nx > LIM) || (nx < -LIM) || (ny > LIM) || (ny < -LIM);
   assign mag_sum = {1'b0, xx_ff} + {1'b0, prod_sh[33:0]};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SETX: begin
            mul_a = cfg.inc_x;
            mul_b = $signed({22'd0, col_ff});
         end
         S_SETY: begin
            mul_a = cfg.inc_y;
            mul_b = $signed({22'd0, row_ff});
         end
         S_XX: begin
            mul_a = zx_ff;
            mul_b = zx_ff;
         end
         S_YY: begin
            mul_a = zy_ff;
            mul_b = zy_ff;
         end
         S_XY: begin
            mul_a = zx_ff;
            mul_b = zy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      zx_in    = zx_ff;
      zy_in    = zy_ff;
      xx_in    = xx_ff;
      yy_in    = yy_ff;
      k_in     = k_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               row_in   = row;
               col_in   = col;
               state_in = S_SETX;
            end
         end
         S_SETX: state_in = S_SETY;
         S_SETY: begin
            cx_in    = $signed({{12{cfg.min_x[31]}}, cfg.min_x}) + prod[43:0];
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // multiplier sees zero operands here, so the cross term starts at zero
            cy_in    = $signed({{12{cfg.min_y[31]}}, cfg.min_y}) + prod[43:0];
            xx_in    = '0;
            yy_in    = '0;
            k_in     = '0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (k_ff == cfg.max_iterations) begin
               count_in = cfg.max_iterations;
               state_in = S_DONE;
            end else if (out_of_box) begin
               count_in = k_ff;
               state_in = S_DONE;
            end else begin
               zx_in    = nx[31:0];
               zy_in    = ny[31:0];
               state_in = S_XX;
            end
         end
         S_XX: state_in = S_YY;
         S_YY: begin
            xx_in    = prod_sh[33:0];
            state_in = S_XY;
         end
         S_XY: begin
            if (mag_sum > ESC_LIM) begin
               count_in = k_ff;
               state_in = S_DONE;
            end else begin
               yy_in    = prod_sh[33:0];
               k_in     = k_ff + 16'd1;
               state_in = S_CHECK;
            end
         end
         S_DONE: begin
            if (take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      row_ff   <= row_in;
      col_ff   <= col_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      zx_ff    <= zx_in;
      zy_ff    <= zy_in;
      xx_ff    <= xx_in;
      yy_ff    <= yy_in;
      k_ff     <= k_in;
      count_ff <= count_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign done.valid = (state_ff == S_DONE);
   assign done.count = count_ff;

endmodule

// ----- rtl/mandelbrot_escape_pixel_core.sv -----
// mandelbrot escape-time pixel core: config, sequencer and output register
// flow: a pixel passes SETX, SETY and LOAD, then CHECK, XX, YY and XY for each iteration
//   on one multiplier, until CHECK or the radius test in XY ends it in DONE
// throughput: one pixel at a time; a new pixel is taken once the result has
//   moved to the output register, even while it still waits there
// reset: synchronous, active high; control and config registers return to their defaults
module mandelbrot_escape_pixel_core import mep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // pixel request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] row, [19:10] col, [23:20] zero
   // pixel result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [23:0] pixel_color, [39:24] iteration_count
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   mep_cfg_type  cfg;
   mep_done_type done;
   logic         seq_idle;
   logic         take;
   logic [23:0]  color;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [39:0]  rsp_data_ff, rsp_data_in;

   mep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // the sequencer owns one pixel from request transfer until the result is handed over
   assign req_tready = seq_idle;

   mep_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .start (req_tvalid),
      .row   (req_tdata[9:0]),
      .col   (req_tdata[19:10]),
      .idle  (seq_idle),
      .take  (take),
      .done  (done)
   );

   // output register frees up when empty or when its result transfers this cycle
   assign take = !rsp_valid_ff || rsp_tready;

   // fill color for points that never escaped when it is nonzero, palette otherwise
   always_comb begin
      if ((done.count == cfg.max_iterations) && (cfg.fill_color != 24'd0)) begin
         color = cfg.fill_color;
      end else begin
         color = mep_palette(done.count[2:0]);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done.valid && take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {done.count, color};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
